FILE: rtl/dled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dled_pkg: shared types and constants for the DLE/ETX packet deframer
// Holds the link control codes, the packet buffer size and the packed
// transaction types of the input and result channels.
// ----------------------------------------------------------------------------
package dled_pkg;

  // Link control codes
  localparam logic [7:0] CODE_DLE = 8'h10;
  localparam logic [7:0] CODE_ETX = 8'h03;

  // Packet buffer: id byte plus payload
  localparam int MAX_PACKET_BYTES = 64;
  localparam int ADDR_W           = $clog2(MAX_PACKET_BYTES);
  localparam int FILL_W           = $clog2(MAX_PACKET_BYTES + 1);

  // Fixed field widths of the result channel
  localparam int POS_W = 6;

  // Input operation codes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]       packet_id;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] byte_position;
    logic [POS_W-1:0] payload_length;
    logic             has_byte;
    logic             is_last;
    logic             overflowed;
  } result_t;

endpackage

FILE: rtl/dle_etx_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_etx_packet_deframer: byte-stuffed serial packet deframer
// Strips DLE stuffing from a received byte stream, buffers one packet and
// replays it as one result per payload byte (one if id-only) on DLE ETX.
// ----------------------------------------------------------------------------
//
//  channel | valid        | stall        | payload          | direction
//  --------+--------------+--------------+------------------+----------
//  input   | item_valid   | item_stall   | item   (item_t)  | into block
//  result  | result_valid | result_stall | result (result_t)| out of block
//
//  Input: a received byte is taken whenever item_stall is low. A DLE ETX
//  that closes a non-empty packet starts the id read and then holds
//  item_stall high for the replay: the id comes out of the buffer in ST_ID,
//  then ST_EMIT hands out one result per cycle while the result register is
//  free, one per payload byte (a single result for an id-only packet).
//  Reset: rst clears the packet flags, fill count, replay sequencer and
//  result valid; buffer contents are not cleared and need not be.
//  Stalls: result_stall freezes the replay with the current result held;
//  a waiting result does not block new input bytes outside a replay.
//
module dle_etx_packet_deframer
  import dled_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,   // take input bytes
    ST_ID   = 3'b010,   // id entry on read port
    ST_EMIT = 3'b100    // payload entry on read port, hand out results
  } state_t;

  state_t state;

  // Packet buffer and its registered read port
  logic [7:0]        store_mem [MAX_PACKET_BYTES];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] rd_addr;

  // Framing state
  logic [FILL_W-1:0] fill_count;
  logic              overflow_seen;
  logic              inside_packet;
  logic              escape_pending;

  // Replay state
  logic [7:0]        pkt_id;
  logic [ADDR_W-1:0] plen;
  logic [ADDR_W-1:0] k;

  logic item_take;
  logic is_dle;
  logic is_etx;
  logic push;
  logic close_pkt;
  logic store_req;
  logic buf_full;
  logic slot_free;
  logic emit;
  logic emit_last;
  logic has_byte;

  // Input side: bytes flow only while no replay runs
  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign is_dle     = (item.rx_byte == CODE_DLE);
  assign is_etx     = (item.rx_byte == CODE_ETX);
  assign push       = item_take && (item.op == OP_PUSH);

  // DLE ETX ends the packet; DLE DLE stores one DLE; DLE x stores x
  assign close_pkt = push && inside_packet && escape_pending && is_etx;
  assign store_req = push && inside_packet &&
                     (is_dle ? escape_pending : !(is_etx && escape_pending));
  assign buf_full  = (fill_count == FILL_W'(MAX_PACKET_BYTES));
  assign mem_we    = store_req && !buf_full;

  // Result side: the output register is free when empty or being taken
  assign slot_free = !result_valid || !result_stall;
  assign emit      = (state == ST_EMIT) && slot_free;
  assign has_byte  = (plen != '0);
  assign emit_last = !has_byte ||
                     ({1'b0, k} + {{ADDR_W{1'b0}}, 1'b1} == {1'b0, plen});

  // Read port: id entry on close, first payload entry after it, then
  // prefetch the next entry as each result leaves
  always_comb begin
    mem_re  = 1'b0;
    rd_addr = '0;
    priority if (close_pkt && fill_count != '0) begin
      mem_re  = 1'b1;
      rd_addr = '0;
    end else if (state == ST_ID) begin
      mem_re  = 1'b1;
      rd_addr = ADDR_W'(1);
    end else if (emit && !emit_last) begin
      mem_re  = 1'b1;
      rd_addr = k + ADDR_W'(2);
    end else begin
      mem_re  = 1'b0;
    end
  end

  // Buffer memory: write and read never fall in the same cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[fill_count[ADDR_W-1:0]] <= item.rx_byte;
    end
    if (mem_re) begin
      mem_q <= store_mem[rd_addr];
    end
  end

  // Framing control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      overflow_seen  <= 1'b0;
      inside_packet  <= 1'b0;
      escape_pending <= 1'b0;
    end else if (item_take) begin
      if (item.op == OP_RESYNC) begin
        // drop packet flags, leave buffer and count alone
        inside_packet  <= 1'b0;
        escape_pending <= 1'b0;
      end else if (!inside_packet) begin
        if (is_dle) begin
          inside_packet  <= 1'b1;
          escape_pending <= 1'b0;
          fill_count     <= '0;
          overflow_seen  <= 1'b0;
        end
      end else if (is_dle) begin
        escape_pending <= !escape_pending;
      end else if (close_pkt) begin
        inside_packet  <= 1'b0;
        escape_pending <= 1'b0;
      end else begin
        escape_pending <= 1'b0;
      end
      if (store_req) begin
        if (buf_full) begin
          overflow_seen <= 1'b1;
        end else begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
    end
  end

  // Replay sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (close_pkt && fill_count != '0) begin
            state <= ST_ID;
          end
        end
        ST_ID: begin
          k     <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              k <= k + ADDR_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Packet length and id captured for the replay
  always_ff @(posedge clk) begin
    if (close_pkt) begin
      plen <= ADDR_W'(fill_count - FILL_W'(1));
    end
    if (state == ST_ID) begin
      pkt_id <= mem_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.packet_id      <= pkt_id;
      result.data_byte      <= has_byte ? mem_q : 8'h00;
      result.byte_position  <= has_byte ? POS_W'(k) : '0;
      result.payload_length <= POS_W'(plen);
      result.has_byte       <= has_byte;
      result.is_last        <= emit_last;
      result.overflowed     <= overflow_seen;
    end
  end

endmodule

FILE: rtl/dled_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dled_checker: port-level checks for the DLE/ETX packet deframer
// Watches the result channel and input stall over time; bound to the top.
// ----------------------------------------------------------------------------
module dled_checker
  import dled_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // While a replay still owes its last result, input stays stalled
  a_replay_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_last |-> item_stall)
    else $error("input taken in the middle of a replay");

  // An id-only result is the single, last result with zero length
  a_id_only_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_byte |->
      result.is_last && result.payload_length == '0 &&
      result.byte_position == '0 && result.data_byte == 8'h00)
    else $error("malformed id-only result");

  // Position stays inside the payload and last marks its final byte
  a_position_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.has_byte |->
      result.byte_position < result.payload_length &&
      (result.is_last == ({1'b0, result.byte_position} + 7'd1 ==
                          {1'b0, result.payload_length})))
    else $error("byte position or last mark out of step");

endmodule

bind dle_etx_packet_deframer dled_checker u_dled_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
